/* hdl/ebd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebd_pkg: shared types and constants of the EAST box decoder
// Fixed-point constants, the CORDIC arctangent table and the structs that
// travel along the pipeline.
// ----------------------------------------------------------------------------
package ebd_pkg;

  localparam logic [15:0] THR_RESET = 16'd16384;

  localparam int CORDIC_STEPS = 16;
  localparam int XY_W = 20;
  localparam int Z_W  = 20;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 20'sd39797;
  localparam logic signed [Z_W-1:0]  PI_Q16      = 20'sd205887;
  localparam logic signed [Z_W-1:0]  HALF_PI_Q16 = 20'sd102944;

  // degrees per radian in Q.17 relative to the Q2.14 input and Q8.7 output
  localparam logic [23:0] DEG_MUL = 24'd7509872;

  localparam logic signed [Z_W-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
    20'sd51472, 20'sd30385, 20'sd16055, 20'sd8150,
    20'sd4091,  20'sd2047,  20'sd1024,  20'sd512,
    20'sd256,   20'sd128,   20'sd64,    20'sd32,
    20'sd16,    20'sd8,     20'sd4,     20'sd2
  };

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   flip;
  } cordic_t;

  typedef struct packed {
    logic [6:0]         cell_x;
    logic [6:0]         cell_y;
    logic signed [16:0] dist_a;    // right minus left
    logic signed [16:0] dist_b;    // bottom minus top
    logic [16:0]        box_w;
    logic [16:0]        box_h;
    logic [15:0]        score;
    logic signed [39:0] deg_prod;
  } side_t;

endpackage

/* hdl/ebd_cordic_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebd_cordic_stage: two CORDIC rotations and one register stage
// Rotates toward zero residual angle for iterations STEP and STEP+1, and
// carries the item's side data and valid bit along.
// ----------------------------------------------------------------------------
module ebd_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  ebd_pkg::cordic_t cordic_i,
  input  ebd_pkg::side_t  side_i,
  output logic            valid_o,
  output ebd_pkg::cordic_t cordic_o,
  output ebd_pkg::side_t  side_o
);

  ebd_pkg::cordic_t cordic_d;
  ebd_pkg::cordic_t cordic_q;
  ebd_pkg::side_t   side_q;
  logic             valid_q;
  logic signed [ebd_pkg::XY_W-1:0] dx;
  logic signed [ebd_pkg::XY_W-1:0] dy;

  always_comb begin
    cordic_d = cordic_i;
    dx = '0;
    dy = '0;
    for (int k = 0; k < 2; k++) begin
      dx = $signed(cordic_d.y) >>> (STEP + k);
      dy = $signed(cordic_d.x) >>> (STEP + k);
      if (!cordic_d.z[ebd_pkg::Z_W-1]) begin
        cordic_d.x = cordic_d.x - dx;
        cordic_d.y = cordic_d.y + dy;
        cordic_d.z = cordic_d.z - ebd_pkg::ATAN_Q16[STEP + k];
      end else begin
        cordic_d.x = cordic_d.x + dx;
        cordic_d.y = cordic_d.y - dy;
        cordic_d.z = cordic_d.z + ebd_pkg::ATAN_Q16[STEP + k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cordic_q <= cordic_d;
    side_q   <= side_i;
  end

  assign valid_o  = valid_q;
  assign cordic_o = cordic_q;
  assign side_o   = side_q;

endmodule

/* hdl/east_box_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// east_box_decoder: rotated-box geometry decode for one feature-map cell
// Thresholds the cell score and turns the cell's edge distances and angle
// into a rotated box: centre, size, angle in degrees and confidence.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive the cell fields with start_i high; a beat is taken
//   at every rising edge with start_i high and busy_o low. busy_o stays low,
//   so one cell can be taken every cycle.
//   Result channel: result_valid_o is high for exactly one cycle per box.
//   The pipeline is twelve register stages deep (entry, eight CORDIC
//   stages with two rotations each, multiply, sum, round and saturate);
//   the strobe is registered in the last of them.
//   Cells whose score is below the threshold leave the pipeline without a
//   strobe. Throughput is one cell per cycle, set by the fully pipelined
//   CORDIC and the four product multipliers.
//   Configuration: the score threshold is written through cfg_valid_i and
//   cfg_data_i; cfg_ready_o is always high. Write it only while idle.
//   Reset clears all valid bits and loads the threshold with 0.5 (16384).
//   The receiver cannot stall: each result must be taken when shown.
// ----------------------------------------------------------------------------
module east_box_decoder #(
  parameter int GRID_MAX    = 128,
  parameter int CELL_STRIDE = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [6:0]         cell_x_i,
  input  logic [6:0]         cell_y_i,
  input  logic [15:0]        score_i,
  input  logic [15:0]        dist_top_i,
  input  logic [15:0]        dist_right_i,
  input  logic [15:0]        dist_bottom_i,
  input  logic [15:0]        dist_left_i,
  input  logic signed [15:0] angle_rad_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i,
  output logic               result_valid_o,
  output logic signed [18:0] center_x_o,
  output logic signed [18:0] center_y_o,
  output logic [16:0]        box_width_o,
  output logic [16:0]        box_height_o,
  output logic signed [14:0] angle_deg_o,
  output logic [15:0]        confidence_o
);

  localparam int NUM_STAGES = ebd_pkg::CORDIC_STEPS / 2;
  localparam int SUM_W      = 48;
  localparam int PROD_W     = ebd_pkg::XY_W + 17;

  logic        accept;
  logic [15:0] thr_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ebd_pkg::THR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  // ---------------- entry stage: fold angle, differences, sums -------------
  logic signed [ebd_pkg::Z_W-1:0] z_raw;
  ebd_pkg::cordic_t cordic_d;
  ebd_pkg::side_t   side_d;

  assign z_raw = ebd_pkg::Z_W'($signed({angle_rad_i, 2'b00}));

  always_comb begin
    cordic_d.x = ebd_pkg::CORDIC_GAIN;
    cordic_d.y = '0;
    if (z_raw > ebd_pkg::HALF_PI_Q16) begin
      cordic_d.z    = ebd_pkg::PI_Q16 - z_raw;
      cordic_d.flip = 1'b1;
    end else if (z_raw < -ebd_pkg::HALF_PI_Q16) begin
      cordic_d.z    = -ebd_pkg::PI_Q16 - z_raw;
      cordic_d.flip = 1'b1;
    end else begin
      cordic_d.z    = z_raw;
      cordic_d.flip = 1'b0;
    end

    // clamp cell index to the grid
    side_d.cell_x = (32'(cell_x_i) > GRID_MAX - 1) ? 7'(GRID_MAX - 1) : cell_x_i;
    side_d.cell_y = (32'(cell_y_i) > GRID_MAX - 1) ? 7'(GRID_MAX - 1) : cell_y_i;
    side_d.dist_a = $signed({1'b0, dist_right_i}) - $signed({1'b0, dist_left_i});
    side_d.dist_b = $signed({1'b0, dist_bottom_i}) - $signed({1'b0, dist_top_i});
    side_d.box_w  = {1'b0, dist_right_i} + {1'b0, dist_left_i};
    side_d.box_h  = {1'b0, dist_top_i} + {1'b0, dist_bottom_i};
    side_d.score  = score_i;
    side_d.deg_prod = angle_rad_i * $signed({1'b0, ebd_pkg::DEG_MUL});
  end

  logic             pipe_valid  [NUM_STAGES+1];
  ebd_pkg::cordic_t pipe_cordic [NUM_STAGES+1];
  ebd_pkg::side_t   pipe_side   [NUM_STAGES+1];
  logic             s0_valid_q;
  ebd_pkg::cordic_t s0_cordic_q;
  ebd_pkg::side_t   s0_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= accept && (score_i >= thr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    s0_cordic_q <= cordic_d;
    s0_side_q   <= side_d;
  end

  assign pipe_valid[0]  = s0_valid_q;
  assign pipe_cordic[0] = s0_cordic_q;
  assign pipe_side[0]   = s0_side_q;

  // ---------------- CORDIC stages ----------------
  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cordic
    ebd_cordic_stage #(
      .STEP (2 * g)
    ) u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (pipe_valid[g]),
      .cordic_i (pipe_cordic[g]),
      .side_i   (pipe_side[g]),
      .valid_o  (pipe_valid[g+1]),
      .cordic_o (pipe_cordic[g+1]),
      .side_o   (pipe_side[g+1])
    );
  end

  // ---------------- multiply stage ----------------
  ebd_pkg::cordic_t cr;
  ebd_pkg::side_t   sd;
  logic signed [ebd_pkg::XY_W-1:0] cs;
  logic signed [ebd_pkg::XY_W-1:0] sn;
  logic signed [PROD_W-1:0] p_ca_d, p_sb_d, p_sa_d, p_cb_d;
  logic signed [PROD_W-1:0] p_ca_q, p_sb_q, p_sa_q, p_cb_q;
  logic           s9_valid_q;
  ebd_pkg::side_t s9_side_q;

  assign cr = pipe_cordic[NUM_STAGES];
  assign sd = pipe_side[NUM_STAGES];
  assign sn = cr.y;
  assign cs = cr.flip ? -cr.x : cr.x;

  assign p_ca_d = cs * sd.dist_a;
  assign p_sb_d = sn * sd.dist_b;
  assign p_sa_d = sn * sd.dist_a;
  assign p_cb_d = cs * sd.dist_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_valid_q <= 1'b0;
    end else begin
      s9_valid_q <= pipe_valid[NUM_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    p_ca_q    <= p_ca_d;
    p_sb_q    <= p_sb_d;
    p_sa_q    <= p_sa_d;
    p_cb_q    <= p_cb_d;
    s9_side_q <= sd;
  end

  // ---------------- sum stage: twice the centre in Q.23 ----------------
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(65536);

  logic signed [SUM_W-1:0] org_x, org_y;
  logic signed [SUM_W-1:0] sum_x_d, sum_y_d, sum_x_q, sum_y_q;
  logic           s10_valid_q;
  ebd_pkg::side_t s10_side_q;

  assign org_x = $signed(SUM_W'(s9_side_q.cell_x) * SUM_W'(CELL_STRIDE)) <<< 24;
  assign org_y = $signed(SUM_W'(s9_side_q.cell_y) * SUM_W'(CELL_STRIDE)) <<< 24;
  assign sum_x_d = org_x + SUM_W'(p_ca_q) + SUM_W'(p_sb_q) + ROUND_HALF;
  assign sum_y_d = org_y - SUM_W'(p_sa_q) + SUM_W'(p_cb_q) + ROUND_HALF;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s10_valid_q <= 1'b0;
    end else begin
      s10_valid_q <= s9_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_x_q    <= sum_x_d;
    sum_y_q    <= sum_y_d;
    s10_side_q <= s9_side_q;
  end

  // ---------------- round and saturate ----------------
  localparam logic signed [SUM_W-1:0] CEN_MAX = SUM_W'(262143);
  localparam logic signed [SUM_W-1:0] CEN_MIN = -SUM_W'(262144);
  localparam logic signed [41:0] DEG_HALF = 42'sd8388608;
  localparam logic signed [41:0] DEG_MAX  = 42'sd16383;
  localparam logic signed [41:0] DEG_MIN  = -42'sd16384;

  logic signed [SUM_W-1:0] sh_x, sh_y;
  logic signed [41:0]      deg_num, deg_sh;
  logic signed [18:0]      cen_x_d, cen_y_d;
  logic signed [14:0]      deg_d;

  assign sh_x    = sum_x_q >>> 17;
  assign sh_y    = sum_y_q >>> 17;
  assign deg_num = -42'(s10_side_q.deg_prod) + DEG_HALF;
  assign deg_sh  = deg_num >>> 24;

  always_comb begin
    if (sh_x > CEN_MAX) begin
      cen_x_d = CEN_MAX[18:0];
    end else if (sh_x < CEN_MIN) begin
      cen_x_d = CEN_MIN[18:0];
    end else begin
      cen_x_d = sh_x[18:0];
    end
    if (sh_y > CEN_MAX) begin
      cen_y_d = CEN_MAX[18:0];
    end else if (sh_y < CEN_MIN) begin
      cen_y_d = CEN_MIN[18:0];
    end else begin
      cen_y_d = sh_y[18:0];
    end
    if (deg_sh > DEG_MAX) begin
      deg_d = DEG_MAX[14:0];
    end else if (deg_sh < DEG_MIN) begin
      deg_d = DEG_MIN[14:0];
    end else begin
      deg_d = deg_sh[14:0];
    end
  end

  logic result_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= s10_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    center_x_o   <= cen_x_d;
    center_y_o   <= cen_y_d;
    box_width_o  <= s10_side_q.box_w;
    box_height_o <= s10_side_q.box_h;
    angle_deg_o  <= deg_d;
    confidence_o <= s10_side_q.score;
  end

  assign result_valid_o = result_valid_q;

endmodule

/* hdl/ebd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebd_checker: port-level checks of the EAST box decoder
// Watches the command, config and result ports for throughput, latency, the
// angle range and idle-only threshold writes; bound to the top level below.
// ----------------------------------------------------------------------------
module ebd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic               result_valid_o,
  input logic signed [14:0] angle_deg_o
);

  localparam int LATENCY = 12;

  // the pipeline never holds off a beat
  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o && cfg_ready_o)
    else $error("decoder stalled a beat");

  // every result comes from a beat taken a fixed number of edges earlier
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without matching accepted beat");

  // a 16-bit Q2.14 angle maps into -14667 .. 14668 in Q8.7 degrees
  a_angle_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (angle_deg_o >= -15'sd14667) && (angle_deg_o <= 15'sd14668))
    else $error("angle out of range");

  // write the threshold only while no beat enters and no result leaves
  a_cfg_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |-> !result_valid_o && !start_i)
    else $error("configuration written while busy");

endmodule

bind east_box_decoder ebd_checker u_ebd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .cfg_valid_i    (cfg_valid_i),
  .cfg_ready_o    (cfg_ready_o),
  .result_valid_o (result_valid_o),
  .angle_deg_o    (angle_deg_o)
);

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the EAST box decoder
// Streams feature-map cells into the decoder under several score thresholds
// and sender gap rates. Every box is predicted in the bench, with its own
// CORDIC, and each strobed result is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int     GRID_MAX        = 128;
  localparam int     CELL_STRIDE     = 4;
  localparam int     ROT_STEPS       = 16;
  localparam longint ROT_GAIN        = 39797;
  localparam longint PI_Q16          = 205887;
  localparam longint HALF_PI_Q16     = 102944;
  localparam longint DEG_PER_RAD     = 7509872;
  localparam int     DRAIN_CYCLES    = 20;
  localparam int     STALL_LIMIT     = 4000;
  localparam int     CELLS_PER_PHASE = 130;

  typedef struct packed {
    logic [6:0]  cell_x;
    logic [6:0]  cell_y;
    logic [15:0] score;
    logic [15:0] dist_top;
    logic [15:0] dist_right;
    logic [15:0] dist_bottom;
    logic [15:0] dist_left;
    logic [15:0] angle_rad;
  } cell_t;

  typedef struct {
    logic signed [18:0] center_x;
    logic signed [18:0] center_y;
    logic [16:0]        box_width;
    logic [16:0]        box_height;
    logic signed [14:0] angle_deg;
    logic [15:0]        confidence;
  } box_t;

  class box_scoreboard;
    logic [15:0] threshold;
    box_t        pending_boxes[$];
    int          errors;
    int          cells;
    int          boxes;
    longint      atan_tbl[ROT_STEPS] = '{
      51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2
    };

    function new();
      threshold = ebd_pkg::THR_RESET;
      errors    = 0;
      cells     = 0;
      boxes     = 0;
    endfunction

    function longint sat_field(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function bit predict_box(cell_t c, output box_t b);
      longint ang, z, x, y, dx, dy, sn, cs;
      longint cx, cy, dt, dr, db, dl, h, w, ax, ay, deg;
      bit     flip;
      int     i;
      if (c.score < threshold) return 1'b0;
      cx = (c.cell_x > GRID_MAX - 1) ? GRID_MAX - 1 : c.cell_x;
      cy = (c.cell_y > GRID_MAX - 1) ? GRID_MAX - 1 : c.cell_y;
      dt = c.dist_top;
      dr = c.dist_right;
      db = c.dist_bottom;
      dl = c.dist_left;
      ang = longint'($signed(c.angle_rad));
      z = ang * 4;
      flip = 1'b0;
      // fold beyond +-pi/2 through pi: keep the sine, negate the cosine
      if (z > HALF_PI_Q16) begin
        z = PI_Q16 - z;
        flip = 1'b1;
      end else if (z < -HALF_PI_Q16) begin
        z = -PI_Q16 - z;
        flip = 1'b1;
      end
      x = ROT_GAIN;
      y = 0;
      for (i = 0; i < ROT_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= atan_tbl[i];
        end else begin
          x += dx;
          y -= dy;
          z += atan_tbl[i];
        end
      end
      sn = y;
      cs = flip ? -x : x;
      h = dt + db;
      w = dr + dl;
      // twice the centre in Q.23, then round half up down to Q.7
      ax = 2 * (cx * CELL_STRIDE * 128 * 65536 + cs * dr + sn * db) - sn * h - cs * w;
      ay = 2 * (cy * CELL_STRIDE * 128 * 65536 - sn * dr + cs * db) - cs * h + sn * w;
      ax = (ax + 64'sd65536) >>> 17;
      ay = (ay + 64'sd65536) >>> 17;
      deg = (-ang * DEG_PER_RAD + 64'sd8388608) >>> 24;
      b.center_x   = 19'(sat_field(ax, 19));
      b.center_y   = 19'(sat_field(ay, 19));
      b.box_width  = 17'(w);
      b.box_height = 17'(h);
      b.angle_deg  = 15'(sat_field(deg, 15));
      b.confidence = c.score;
      return 1'b1;
    endfunction

    function void note_cell(cell_t c);
      box_t b;
      cells++;
      if (predict_box(c, b)) pending_boxes = {pending_boxes, b};
    endfunction

    function void check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $display("%0t %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_box(box_t got);
      box_t exp_b;
      boxes++;
      if (pending_boxes.size() == 0) begin
        $display("%0t unexpected box: expected none, got center %0d,%0d",
                 $time, got.center_x, got.center_y);
        errors++;
        return;
      end
      exp_b = pending_boxes.pop_front();
      check_field("center_x", longint'(exp_b.center_x), longint'(got.center_x));
      check_field("center_y", longint'(exp_b.center_y), longint'(got.center_y));
      check_field("box_width", longint'(exp_b.box_width), longint'(got.box_width));
      check_field("box_height", longint'(exp_b.box_height), longint'(got.box_height));
      check_field("angle_deg", longint'(exp_b.angle_deg), longint'(got.angle_deg));
      check_field("confidence", longint'(exp_b.confidence), longint'(got.confidence));
    endfunction
  endclass

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               start_i       = 1'b0;
  logic               busy_o;
  logic [6:0]         cell_x_i      = '0;
  logic [6:0]         cell_y_i      = '0;
  logic [15:0]        score_i       = '0;
  logic [15:0]        dist_top_i    = '0;
  logic [15:0]        dist_right_i  = '0;
  logic [15:0]        dist_bottom_i = '0;
  logic [15:0]        dist_left_i   = '0;
  logic signed [15:0] angle_rad_i   = '0;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [15:0]        cfg_data_i    = '0;
  logic               result_valid_o;
  logic signed [18:0] center_x_o;
  logic signed [18:0] center_y_o;
  logic [16:0]        box_width_o;
  logic [16:0]        box_height_o;
  logic signed [14:0] angle_deg_o;
  logic [15:0]        confidence_o;

  box_scoreboard sb = new();
  int            idle_cycles = 0;
  int            thr_writes  = 0;

  east_box_decoder #(
    .GRID_MAX    (GRID_MAX),
    .CELL_STRIDE (CELL_STRIDE)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cell_x_i       (cell_x_i),
    .cell_y_i       (cell_y_i),
    .score_i        (score_i),
    .dist_top_i     (dist_top_i),
    .dist_right_i   (dist_right_i),
    .dist_bottom_i  (dist_bottom_i),
    .dist_left_i    (dist_left_i),
    .angle_rad_i    (angle_rad_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .center_x_o     (center_x_o),
    .center_y_o     (center_y_o),
    .box_width_o    (box_width_o),
    .box_height_o   (box_height_o),
    .angle_deg_o    (angle_deg_o),
    .confidence_o   (confidence_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin : monitor
    box_t got;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        sb.note_cell(cell_t'{cell_x_i, cell_y_i, score_i, dist_top_i, dist_right_i,
                             dist_bottom_i, dist_left_i, angle_rad_i});
      end
      if (result_valid_o) begin
        got.center_x   = center_x_o;
        got.center_y   = center_y_o;
        got.box_width  = box_width_o;
        got.box_height = box_height_o;
        got.angle_deg  = angle_deg_o;
        got.confidence = confidence_o;
        sb.check_box(got);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t watchdog: %0d cycles without a beat", $time, idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic drive_fields(cell_t c);
    cell_x_i      <= c.cell_x;
    cell_y_i      <= c.cell_y;
    score_i       <= c.score;
    dist_top_i    <= c.dist_top;
    dist_right_i  <= c.dist_right;
    dist_bottom_i <= c.dist_bottom;
    dist_left_i   <= c.dist_left;
    angle_rad_i   <= c.angle_rad;
  endtask

  // hold start low for random gaps with noise on the fields, then send one beat
  task automatic send_cell(cell_t c, int idle_pct);
    logic [127:0] noise;
    while ($urandom_range(99) < idle_pct) begin
      noise = {$urandom, $urandom, $urandom, $urandom};
      start_i <= 1'b0;
      drive_fields(cell_t'(noise[$bits(cell_t)-1:0]));
      @(posedge clk_i);
    end
    drive_fields(c);
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // cells below threshold leave no trace, so wait out the pipe after the last box
  task automatic wait_drained();
    while (sb.pending_boxes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.threshold = value;
    thr_writes++;
  endtask

  function automatic logic [15:0] random_score(logic [15:0] thr);
    case ($urandom_range(7))
      0, 1:    return thr;
      2:       return thr - 16'd1;
      3:       return 16'hFFFF;
      4:       return 16'd32768;
      5:       return 16'($urandom);
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  function automatic logic [15:0] random_dist();
    case ($urandom_range(5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(4095));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_angle();
    case ($urandom_range(9))
      0:       return 16'd25736;
      1:       return -16'sd25736;
      2:       return 16'($urandom);
      3:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom_range(51472) - 25736);
    endcase
  endfunction

  function automatic cell_t random_cell(logic [15:0] thr);
    cell_t c;
    c.cell_x      = 7'($urandom);
    c.cell_y      = 7'($urandom);
    c.score       = random_score(thr);
    c.dist_top    = random_dist();
    c.dist_right  = random_dist();
    c.dist_bottom = random_dist();
    c.dist_left   = random_dist();
    c.angle_rad   = random_angle();
    return c;
  endfunction

  task automatic run_phase(logic [15:0] thr, int idle_pct);
    wait_drained();
    write_threshold(thr);
    repeat (CELLS_PER_PHASE) send_cell(random_cell(thr), idle_pct);
    start_i <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed cells under the reset threshold
    send_cell(cell_t'{7'd0, 7'd0, 16'd16384, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 0);
    send_cell(cell_t'{7'd0, 7'd0, 16'd16383, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 0);
    send_cell(cell_t'{7'd5, 7'd9, 16'd0, 16'd1280, 16'd1280, 16'd1280, 16'd1280, 16'd0}, 0);
    send_cell(cell_t'{7'd127, 7'd127, 16'd32768, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'd0}, 0);
    send_cell(cell_t'{7'd127, 7'd0, 16'hFFFF, 16'd640, 16'd2560, 16'd1280, 16'd320,
                      16'd1}, 0);
    send_cell(cell_t'{7'd0, 7'd127, 16'd20000, 16'd640, 16'd2560, 16'd1280, 16'd320,
                      16'hFFFF}, 0);
    send_cell(cell_t'{7'd10, 7'd20, 16'd30000, 16'd1280, 16'd2560, 16'd1280, 16'd2560,
                      16'd25736}, 0);
    send_cell(cell_t'{7'd10, 7'd20, 16'd30000, 16'd1280, 16'd2560, 16'd1280, 16'd2560,
                      -16'sd25736}, 0);
    send_cell(cell_t'{7'd10, 7'd20, 16'd30000, 16'd1280, 16'd2560, 16'd1280, 16'd2560,
                      16'd25737}, 0);
    send_cell(cell_t'{7'd10, 7'd20, 16'd30000, 16'd1280, 16'd2560, 16'd1280, 16'd2560,
                      -16'sd25737}, 0);
    send_cell(cell_t'{7'd64, 7'd33, 16'd30000, 16'd1280, 16'd2560, 16'd1280, 16'd2560,
                      16'h7FFF}, 0);
    send_cell(cell_t'{7'd64, 7'd33, 16'd30000, 16'd1280, 16'd2560, 16'd1280, 16'd2560,
                      16'h8000}, 0);
    send_cell(cell_t'{7'd64, 7'd33, 16'd30000, 16'd1280, 16'd2560, 16'd1280, 16'd2560,
                      16'd12868}, 0);
    send_cell(cell_t'{7'd64, 7'd33, 16'd30000, 16'd1280, 16'd2560, 16'd1280, 16'd2560,
                      -16'sd12868}, 0);
    send_cell(cell_t'{7'd3, 7'd3, 16'd16384, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd12868}, 0);
    send_cell(cell_t'{7'd3, 7'd3, 16'd16384, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd12868}, 0);
    send_cell(cell_t'{7'd3, 7'd3, 16'd16384, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd12868}, 0);
    send_cell(cell_t'{7'd3, 7'd3, 16'd16384, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd12868}, 0);
    send_cell(cell_t'{7'd0, 7'd0, 16'd32768, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'h8000}, 0);
    send_cell(cell_t'{7'd127, 7'd127, 16'd32768, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0,
                      16'h7FFF}, 0);
    start_i <= 1'b0;

    // random traffic across threshold extremes and gap rates
    run_phase(16'd0, 0);
    run_phase(16'd32768, 66);
    run_phase(16'hFFFF, 26);
    run_phase(ebd_pkg::THR_RESET, 66);
    run_phase(16'($urandom_range(32768)), 0);
    wait_drained();

    $display("Covered %0d cells and %0d boxes over %0d threshold writes,",
             sb.cells, sb.boxes, thr_writes);
    $display("with sender gap rates of 0, 26 and 66 percent; %0d mismatches.", sb.errors);
    if (sb.errors == 0 && sb.pending_boxes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
